// File: design/tidr_pkg.sv
package tidr_pkg;

    localparam int unsigned XID_W = 32;
    localparam int unsigned CONN_W = 8;
    localparam int unsigned CTR_W = 24;
    localparam int unsigned REQ_W = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP_KEEP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP_DROP = 2'd2;

    localparam logic [XID_W-1:0] XID_MISS = 32'hFFFF_FFFF;
    localparam logic [CTR_W-1:0] CTR_LAST = 24'hFF_FFFE;
    localparam logic [CTR_W-1:0] CTR_FIRST = 24'h00_0001;

    typedef struct packed {
        logic [XID_W-1:0] tag;
        logic [XID_W-1:0] orig;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic evict;
        logic drop;
    } cell_ctrl_t;

endpackage

// File: design/tidr_cell.sv
module tidr_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tidr_pkg::cell_ctrl_t          ctrl,
    input  logic                          prev_valid,
    input  logic                          nbr_valid,
    input  tidr_pkg::entry_t              nbr_entry,
    input  tidr_pkg::entry_t              new_entry,
    input  logic [tidr_pkg::XID_W-1:0]    want,
    input  logic                          above_in,
    input  logic [tidr_pkg::XID_W-1:0]    sel_in,
    output logic                          valid,
    output logic                          above_out,
    output logic [tidr_pkg::XID_W-1:0]    sel_out,
    output tidr_pkg::entry_t              entry
);

    logic             valid_reg;
    logic             valid_next;
    tidr_pkg::entry_t entry_reg;
    tidr_pkg::entry_t entry_next;
    logic             match;
    logic             first;
    logic             shift;
    logic             load;

    assign match     = valid_reg && (entry_reg.tag == want);
    assign first     = match && !above_in;
    assign above_out = above_in || match;
    assign sel_out   = sel_in | (first ? entry_reg.orig : '0);

    // shift toward the oldest end on eviction, or behind a removed match
    assign shift = ctrl.evict || (ctrl.drop && above_out);
    assign load  = ctrl.insert && !ctrl.evict && !valid_reg && prev_valid;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (shift)
        begin
            valid_next = nbr_valid;
            entry_next = nbr_entry;
        end
        else if (load)
        begin
            valid_next = 1'b1;
            entry_next = new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// File: design/transaction_id_remap_table_core.sv
// channel | signals                                          | transfer when
// in      | in_valid in_ready req_type conn_id orig_xid tagged_xid | in_valid && in_ready
// out     | out_valid out_ready result_xid hit evicted        | out_valid && out_ready
//
// One request per cycle; the result is registered and appears the cycle after
// acceptance. Tags are matched in all cells at once, and the oldest-match
// priority and result select ripple along the row of cells.
// Reset empties the table and clears the tag counter; no clearing pass.
// in_ready is low only while a result waits and out_ready is low.
module transaction_id_remap_table_core #(
    parameter int unsigned CHAIN_LIMIT = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tidr_pkg::REQ_W-1:0]   req_type,
    input  logic [tidr_pkg::CONN_W-1:0]  conn_id,
    input  logic [tidr_pkg::XID_W-1:0]   orig_xid,
    input  logic [tidr_pkg::XID_W-1:0]   tagged_xid,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tidr_pkg::XID_W-1:0]   result_xid,
    output logic                         hit,
    output logic                         evicted
);

    localparam int unsigned DEPTH = CHAIN_LIMIT - 1;

    logic                          take;
    logic                          full;
    logic                          is_insert;
    logic                          is_lookup;
    logic [tidr_pkg::CTR_W-1:0]    ctr_reg;
    logic [tidr_pkg::CTR_W-1:0]    ctr_next;
    tidr_pkg::entry_t              new_entry;
    tidr_pkg::cell_ctrl_t          ctrl;
    logic [DEPTH-1:0]              valid_w;
    tidr_pkg::entry_t              entry_w [DEPTH];
    logic [DEPTH:0]                above_w;
    logic [tidr_pkg::XID_W-1:0]    sel_w [DEPTH+1];
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [tidr_pkg::XID_W-1:0]    result_reg;
    logic [tidr_pkg::XID_W-1:0]    result_next;
    logic                          hit_reg;
    logic                          hit_next;
    logic                          evicted_reg;
    logic                          evicted_next;

    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign full      = valid_w[DEPTH-1];
    assign is_insert = (req_type == tidr_pkg::REQ_INSERT);
    assign is_lookup = (req_type == tidr_pkg::REQ_LOOKUP_KEEP)
                    || (req_type == tidr_pkg::REQ_LOOKUP_DROP);

    assign ctr_next = (ctr_reg == tidr_pkg::CTR_LAST) ? tidr_pkg::CTR_FIRST
                    : ctr_reg + tidr_pkg::CTR_W'(1);

    assign new_entry.tag  = {conn_id, ctr_next};
    assign new_entry.orig = orig_xid;

    assign ctrl.insert = take && is_insert;
    assign ctrl.evict  = take && is_insert && full;
    assign ctrl.drop   = take && (req_type == tidr_pkg::REQ_LOOKUP_DROP);

    assign above_w[0] = 1'b0;
    assign sel_w[0]   = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic             prev_v;
        logic             nbr_v;
        tidr_pkg::entry_t nbr_e;

        if (i == 0)
        begin : g_head
            assign prev_v = 1'b1;
        end
        else
        begin : g_body
            assign prev_v = valid_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign nbr_v = ctrl.evict;
            assign nbr_e = new_entry;
        end
        else
        begin : g_link
            assign nbr_v = valid_w[i+1];
            assign nbr_e = entry_w[i+1];
        end

        tidr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_valid (prev_v),
            .nbr_valid  (nbr_v),
            .nbr_entry  (nbr_e),
            .new_entry  (new_entry),
            .want       (tagged_xid),
            .above_in   (above_w[i]),
            .sel_in     (sel_w[i]),
            .valid      (valid_w[i]),
            .above_out  (above_w[i+1]),
            .sel_out    (sel_w[i+1]),
            .entry      (entry_w[i])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        hit_next       = hit_reg;
        evicted_next   = evicted_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            if (is_insert)
            begin
                result_next  = new_entry.tag;
                hit_next     = 1'b1;
                evicted_next = full;
            end
            else if (is_lookup && above_w[DEPTH])
            begin
                result_next  = sel_w[DEPTH];
                hit_next     = 1'b1;
                evicted_next = 1'b0;
            end
            else
            begin
                result_next  = tidr_pkg::XID_MISS;
                hit_next     = 1'b0;
                evicted_next = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ctr_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (ctrl.insert)
            begin
                ctr_reg <= ctr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg  <= result_next;
        hit_reg     <= hit_next;
        evicted_reg <= evicted_next;
    end

    assign out_valid  = out_valid_reg;
    assign result_xid = result_reg;
    assign hit        = hit_reg;
    assign evicted    = evicted_reg;

endmodule

// File: dv/tb_transaction_id_remap_table_core.sv
`timescale 1ns / 1ps

module tb_transaction_id_remap_table_core;

    localparam int unsigned CHAIN_LIMIT = 10;
    localparam int unsigned TBL_DEPTH = CHAIN_LIMIT - 1;
    localparam logic [tidr_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned RX_HOLD_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [tidr_pkg::XID_W-1:0] xid;
        logic                       hit;
        logic                       evicted;
    } remap_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [tidr_pkg::REQ_W-1:0]   req_type;
    logic [tidr_pkg::CONN_W-1:0]  conn_id;
    logic [tidr_pkg::XID_W-1:0]   orig_xid;
    logic [tidr_pkg::XID_W-1:0]   tagged_xid;
    logic                         out_valid;
    logic                         out_ready;
    logic [tidr_pkg::XID_W-1:0]   result_xid;
    logic                         hit;
    logic                         evicted;

    // shadow of the table
    logic [tidr_pkg::XID_W-1:0]   tbl_tag [TBL_DEPTH];
    logic [tidr_pkg::XID_W-1:0]   tbl_orig [TBL_DEPTH];
    int unsigned                  tbl_occ = 0;
    logic [tidr_pkg::CTR_W-1:0]   tbl_ctr = '0;

    remap_result_t                remap_exp_q [$];
    logic [tidr_pkg::XID_W-1:0]   issued_tags [$];

    int unsigned        mismatch_count = 0;
    int unsigned        sent_count = 0;
    int unsigned        result_count = 0;
    int unsigned        evict_count = 0;
    int unsigned        lookup_hit_count = 0;
    int unsigned        cycle_count = 0;

    bit                 rx_random = 1'b1;
    bit                 rx_hold_req = 1'b0;
    int unsigned        rx_stall_left = 0;

    transaction_id_remap_table_core #(
        .CHAIN_LIMIT(CHAIN_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .conn_id(conn_id),
        .orig_xid(orig_xid),
        .tagged_xid(tagged_xid),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_xid(result_xid),
        .hit(hit),
        .evicted(evicted)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
    end

    initial
    begin
        wait (cycle_count > CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, remap_exp_q.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic void drop_entry(input int unsigned pos);
        for (int unsigned k = pos; k + 1 < tbl_occ; k++)
        begin
            tbl_tag[k] = tbl_tag[k + 1];
            tbl_orig[k] = tbl_orig[k + 1];
        end
        tbl_occ--;
    endfunction

    task automatic predict_remap(input logic [tidr_pkg::REQ_W-1:0] rt,
                                 input logic [tidr_pkg::CONN_W-1:0] cid,
                                 input logic [tidr_pkg::XID_W-1:0] oxid,
                                 input logic [tidr_pkg::XID_W-1:0] txid);
        remap_result_t r;
        logic [tidr_pkg::XID_W-1:0] tag;
        bit found;
        r.xid = tidr_pkg::XID_MISS;
        r.hit = 1'b0;
        r.evicted = 1'b0;
        found = 1'b0;
        if (rt == tidr_pkg::REQ_INSERT)
        begin
            tbl_ctr = (tbl_ctr == tidr_pkg::CTR_LAST) ? tidr_pkg::CTR_FIRST : tbl_ctr + 1'b1;
            tag = {cid, tbl_ctr};
            if (tbl_occ + 1 >= CHAIN_LIMIT)
            begin
                drop_entry(0);
                r.evicted = 1'b1;
            end
            tbl_tag[tbl_occ] = tag;
            tbl_orig[tbl_occ] = oxid;
            tbl_occ++;
            r.xid = tag;
            r.hit = 1'b1;
            if (issued_tags.size() >= 32)
                void'(issued_tags.pop_front());
            issued_tags.push_back(tag);
        end
        else if (rt == tidr_pkg::REQ_LOOKUP_KEEP || rt == tidr_pkg::REQ_LOOKUP_DROP)
        begin
            for (int unsigned k = 0; k < tbl_occ; k++)
            begin
                if (!found && tbl_tag[k] == txid)
                begin
                    found = 1'b1;
                    r.xid = tbl_orig[k];
                    r.hit = 1'b1;
                    lookup_hit_count++;
                    if (rt == tidr_pkg::REQ_LOOKUP_DROP)
                        drop_entry(k);
                end
            end
        end
        remap_exp_q.push_back(r);
    endtask

    task automatic report_mismatch(input string field, input logic [tidr_pkg::XID_W-1:0] got,
                                   input logic [tidr_pkg::XID_W-1:0] want);
        $display("error: result %0d %s got %h want %h at cycle %0d",
                 result_count, field, got, want, cycle_count);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        remap_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (remap_exp_q.size() == 0)
            begin
                report_mismatch("unexpected transfer", result_xid, tidr_pkg::XID_MISS);
            end
            else
            begin
                want = remap_exp_q.pop_front();
                if (result_xid !== want.xid)
                    report_mismatch("result_xid", result_xid, want.xid);
                if (hit !== want.hit)
                    report_mismatch("hit", tidr_pkg::XID_W'(hit), tidr_pkg::XID_W'(want.hit));
                if (evicted !== want.evicted)
                    report_mismatch("evicted", tidr_pkg::XID_W'(evicted),
                                    tidr_pkg::XID_W'(want.evicted));
                if (want.evicted)
                    evict_count++;
            end
            result_count++;
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else if (rx_stall_left > 0)
            begin
                out_ready <= 1'b0;
                rx_stall_left--;
            end
            else if (rx_random && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                rx_stall_left = $urandom_range(1, 13) - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_req(input logic [tidr_pkg::REQ_W-1:0] rt,
                            input logic [tidr_pkg::CONN_W-1:0] cid,
                            input logic [tidr_pkg::XID_W-1:0] oxid,
                            input logic [tidr_pkg::XID_W-1:0] txid);
        in_valid <= 1'b1;
        req_type <= rt;
        conn_id <= cid;
        orig_xid <= oxid;
        tagged_xid <= txid;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_remap(rt, cid, oxid, txid);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic tx_idle(input int unsigned n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (remap_exp_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [tidr_pkg::XID_W-1:0] pick_lookup_tag();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70 && tbl_occ > 0)
            return tbl_tag[$urandom_range(0, tbl_occ - 1)];
        if (sel < 88 && issued_tags.size() > 0)
            return issued_tags[$urandom_range(0, issued_tags.size() - 1)];
        return $urandom();
    endfunction

    task automatic send_random(input bit with_gaps);
        int unsigned sel;
        logic [tidr_pkg::REQ_W-1:0] rt;
        logic [tidr_pkg::XID_W-1:0] txid;
        if (with_gaps && $urandom_range(0, 3) == 0)
            tx_idle($urandom_range(1, 13));
        sel = $urandom_range(0, 99);
        if (sel < 45)
            rt = tidr_pkg::REQ_INSERT;
        else if (sel < 70)
            rt = tidr_pkg::REQ_LOOKUP_KEEP;
        else if (sel < 95)
            rt = tidr_pkg::REQ_LOOKUP_DROP;
        else
            rt = REQ_UNUSED;
        txid = (rt == tidr_pkg::REQ_INSERT) ? $urandom() : pick_lookup_tag();
        send_req(rt, tidr_pkg::CONN_W'($urandom_range(0, 255)), $urandom(), txid);
    endtask

    task automatic test_basic_lookups();
        logic [tidr_pkg::XID_W-1:0] tag_lo;
        logic [tidr_pkg::XID_W-1:0] tag_hi;
        logic [tidr_pkg::XID_W-1:0] tag_mid;
        send_req(tidr_pkg::REQ_LOOKUP_KEEP, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_req(tidr_pkg::REQ_INSERT, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
        tag_lo = issued_tags[$];
        send_req(tidr_pkg::REQ_INSERT, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
        tag_hi = issued_tags[$];
        send_req(tidr_pkg::REQ_INSERT, 8'hA5, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        tag_mid = issued_tags[$];
        // stored ID of all ones must still report a hit
        send_req(tidr_pkg::REQ_LOOKUP_KEEP, 8'h00, 32'h0, tag_hi);
        send_req(tidr_pkg::REQ_LOOKUP_KEEP, 8'hFF, 32'hFFFF_FFFF, tag_lo);
        send_req(tidr_pkg::REQ_LOOKUP_DROP, 8'h00, 32'h0, tag_mid);
        send_req(tidr_pkg::REQ_LOOKUP_KEEP, 8'h00, 32'h0, tag_mid);
        send_req(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, tag_lo);
        send_req(tidr_pkg::REQ_LOOKUP_DROP, 8'h00, 32'h0, tag_lo);
        send_req(tidr_pkg::REQ_LOOKUP_DROP, 8'h00, 32'h0, tag_lo);
        send_req(tidr_pkg::REQ_LOOKUP_KEEP, 8'h00, 32'h0, 32'hFFFF_FFFF);
        send_req(tidr_pkg::REQ_LOOKUP_DROP, 8'h00, 32'h0, 32'h0000_0000);
        wait_drained();
    endtask

    task automatic test_eviction();
        logic [tidr_pkg::XID_W-1:0] first_tag;
        first_tag = '0;
        for (int unsigned i = 0; i < CHAIN_LIMIT + 2; i++)
        begin
            send_req(tidr_pkg::REQ_INSERT, i[tidr_pkg::CONN_W-1:0] * 8'd23,
                     $urandom(), $urandom());
            if (i == 0)
                first_tag = issued_tags[$];
        end
        send_req(tidr_pkg::REQ_LOOKUP_KEEP, 8'h00, 32'h0, first_tag);
        send_req(tidr_pkg::REQ_LOOKUP_DROP, 8'h00, 32'h0, tbl_tag[0]);
        send_req(tidr_pkg::REQ_LOOKUP_DROP, 8'h00, 32'h0, tbl_tag[tbl_occ - 1]);
        wait_drained();
    endtask

    task automatic test_random_mix(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_random((i / 50) % 3 != 2);
        wait_drained();
    endtask

    task automatic test_backpressure();
        rx_hold_req = 1'b1;
        for (int unsigned i = 0; i < 20; i++)
            send_random(1'b0);
        wait_drained();
    endtask

    task automatic test_no_idle(input int unsigned n);
        rx_random = 1'b0;
        for (int unsigned i = 0; i < n; i++)
            send_random(1'b0);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = tidr_pkg::REQ_INSERT;
        conn_id = '0;
        orig_xid = '0;
        tagged_xid = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_lookups();
        test_eviction();
        test_random_mix(300);
        test_backpressure();
        test_random_mix(200);
        test_no_idle(60);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests sent, %0d results checked (%0d evictions, %0d lookup hits)",
                 sent_count, result_count, evict_count, lookup_hit_count);
        $display("covered inserts to capacity, keep/drop lookups, misses, unused code, stalls");
        if (mismatch_count == 0 && remap_exp_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
